@@ hw/rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, needs clock and reset in scope
`define NCM_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ncm assertion failed");

// next-cycle implication
`define NCM_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ncm assertion failed");

`endif

@@ hw/rtl/ncm_pkg.sv @@
`default_nettype none
package ncm_pkg;
   localparam int FRAC_BITS         = 16;
   localparam int QUOT_W            = FRAC_BITS + 1;
   localparam int COLOR_SCALE       = 127;
   localparam int COLOR_W           = 8;
   localparam int COORD_W           = 10;
   localparam int FACE_SIZE_W       = 11;
   localparam int DEF_MAX_FACE_SIZE = 1024;
   localparam logic [FACE_SIZE_W-1:0] FACE_SIZE_RESET = 11'd256;
   localparam logic [QUOT_W-1:0]      QUOT_ONE        = 17'h10000;

   typedef enum logic [2:0] {
      FACE_POS_X = 3'd0,
      FACE_NEG_X = 3'd1,
      FACE_POS_Y = 3'd2,
      FACE_NEG_Y = 3'd3,
      FACE_POS_Z = 3'd4,
      FACE_NEG_Z = 3'd5
   } face_type;

   function automatic logic [COLOR_W-1:0] to_color(input logic [QUOT_W-1:0] q,
                                                   input logic neg, input logic zero);
      logic [QUOT_W:0]     val;
      logic [QUOT_W+7:0]   prod;
      val  = neg ? ({1'b0, QUOT_ONE} - {1'b0, q}) : ({1'b0, QUOT_ONE} + {1'b0, q});
      prod = (QUOT_W+8)'(val) * (QUOT_W+8)'(COLOR_SCALE);
      if (zero) begin
         return COLOR_W'(COLOR_SCALE);
      end
      return prod[FRAC_BITS+COLOR_W-1:FRAC_BITS];
   endfunction
endpackage
`default_nettype wire

@@ hw/rtl/ncm_sqrt_cell.sv @@
`default_nettype none
module ncm_sqrt_cell import ncm_pkg::*; #(
   parameter int RW    = 27,
   parameter int SIDEW = 34
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire logic [2*RW-1:0]   in_rad,
   input  wire logic [RW+1:0]     in_rem,
   input  wire logic [RW-1:0]     in_root,
   input  wire logic [SIDEW-1:0]  in_side,
   output logic                   out_valid,
   output logic [2*RW-1:0]        out_rad,
   output logic [RW+1:0]          out_rem,
   output logic [RW-1:0]          out_root,
   output logic [SIDEW-1:0]       out_side
);
   logic              valid_ff;
   logic [2*RW-1:0]   rad_ff, rad_in;
   logic [RW+1:0]     rem_ff, rem_in;
   logic [RW-1:0]     root_ff, root_in;
   logic [SIDEW-1:0]  side_ff;
   logic [RW+3:0]     cand, sub, diff;
   logic              fits;

   always_comb begin
      cand    = {in_rem, in_rad[2*RW-1 -: 2]};
      sub     = {2'b00, in_root, 2'b01};
      diff    = cand - sub;
      fits    = (cand >= sub);
      rem_in  = fits ? diff[RW+1:0] : cand[RW+1:0];
      root_in = {in_root[RW-2:0], fits};
      rad_in  = {in_rad[2*RW-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      side_ff <= in_side;
   end

   assign out_valid = valid_ff;
   assign out_rad   = rad_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_side  = side_ff;
endmodule
`default_nettype wire

@@ hw/rtl/ncm_div_cell.sv @@
`default_nettype none
module ncm_div_cell import ncm_pkg::*; #(
   parameter int RW    = 27,
   parameter int SIDEW = 2
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire logic [RW-1:0]     in_rem,
   input  wire logic [RW-1:0]     in_div,
   input  wire logic [QUOT_W-1:0] in_q,
   input  wire logic [SIDEW-1:0]  in_side,
   output logic                   out_valid,
   output logic [RW-1:0]          out_rem,
   output logic [RW-1:0]          out_div,
   output logic [QUOT_W-1:0]      out_q,
   output logic [SIDEW-1:0]       out_side
);
   logic              valid_ff;
   logic [RW-1:0]     rem_ff, rem_in, div_ff;
   logic [QUOT_W-1:0] q_ff, q_in;
   logic [SIDEW-1:0]  side_ff;
   logic [RW:0]       sh, diff;
   logic              fits;

   always_comb begin
      sh     = {in_rem, 1'b0};
      diff   = sh - {1'b0, in_div};
      fits   = (sh >= {1'b0, in_div});
      rem_in = fits ? diff[RW-1:0] : sh[RW-1:0];
      q_in   = {in_q[QUOT_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      rem_ff  <= rem_in;
      div_ff  <= in_div;
      q_ff    <= q_in;
      side_ff <= in_side;
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_div   = div_ff;
   assign out_q     = q_ff;
   assign out_side  = side_ff;
endmodule
`default_nettype wire

@@ hw/rtl/normalization_cubemap_texel.sv @@
`default_nettype none
// Normalization cube map texel generator. One item (face, column, row) is taken in every
// clock; busy is always low. The rgb result is driven on rsp_red/green/blue with rsp_valid
// high for exactly one cycle. The pipeline is four setup stages, one square-root cell per
// result bit of the Q16 vector length, seventeen divider cells per component and an output
// register. The receiver cannot stall, so results must be taken in the cycle they appear.
// csr_wdata must be written only while the pipeline is empty; the block itself does not
// enforce this.
module normalization_cubemap_texel import ncm_pkg::*; #(
   parameter int MAX_FACE_SIZE = DEF_MAX_FACE_SIZE
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic [2:0]             req_face,
   input  wire logic [COORD_W-1:0]     req_column,
   input  wire logic [COORD_W-1:0]     req_row,
   output logic                        rsp_valid,
   output logic [COLOR_W-1:0]          rsp_red,
   output logic [COLOR_W-1:0]          rsp_green,
   output logic [COLOR_W-1:0]          rsp_blue,
   input  wire logic                   csr_we,
   input  wire logic [FACE_SIZE_W-1:0] csr_wdata
);
   `include "assert_macros.svh"

   localparam int CW    = $clog2(MAX_FACE_SIZE);
   localparam int DW    = CW + 1;
   localparam int SW    = CW + 2;
   localparam int LW    = 2 * CW + 2;
   localparam int RW    = CW + 1 + FRAC_BITS;
   localparam int SIDEW = 3 * CW + 4;

   logic [FACE_SIZE_W-1:0] face_size_ff;
   logic [DW-1:0]          d;
   logic [CW-1:0]          dm1, xc, yc;
   logic signed [SW-1:0]   s_in, t_in;

   logic                   s1_valid_ff;
   logic signed [SW-1:0]   s1_s_ff, s1_t_ff;
   logic [CW-1:0]          s1_m_ff;
   logic [2:0]             s1_face_ff;

   logic [CW-1:0]          smag, tmag;
   logic                   sneg, tneg;
   logic [CW-1:0]          mag_in  [0:2];
   logic                   neg_in  [0:2];
   logic                   zero_in;

   logic                   s2_valid_ff, s2_zero_ff;
   logic [CW-1:0]          s2_mag_ff [0:2];
   logic                   s2_neg_ff [0:2];

   logic                   s3_valid_ff, s3_zero_ff;
   logic [CW-1:0]          s3_mag_ff [0:2];
   logic                   s3_neg_ff [0:2];
   logic [2*CW-1:0]        s3_sq_ff  [0:2];

   logic                   s4_valid_ff, s4_zero_ff;
   logic [CW-1:0]          s4_mag_ff [0:2];
   logic                   s4_neg_ff [0:2];
   logic [LW-1:0]          s4_len2_ff;

   logic                   sq_valid [0:RW];
   logic [2*RW-1:0]        sq_rad   [0:RW];
   logic [RW+1:0]          sq_rem   [0:RW];
   logic [RW-1:0]          sq_root  [0:RW];
   logic [SIDEW-1:0]       sq_side  [0:RW];

   logic                   dv_valid [0:2][0:QUOT_W];
   logic [RW-1:0]          dv_rem   [0:2][0:QUOT_W];
   logic [RW-1:0]          dv_div   [0:2][0:QUOT_W];
   logic [QUOT_W-1:0]      dv_q     [0:2][0:QUOT_W];
   logic [1:0]             dv_side  [0:2][0:QUOT_W];

   logic                   rsp_valid_ff;
   logic [COLOR_W-1:0]     red_ff, green_ff, blue_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         face_size_ff <= FACE_SIZE_RESET;
      end else if (csr_we) begin
         face_size_ff <= csr_wdata;
      end
   end

   // stage 1: clamp and center
   always_comb begin
      if (int'(face_size_ff) < 2) begin
         d = DW'(2);
      end else if (int'(face_size_ff) > MAX_FACE_SIZE) begin
         d = DW'(MAX_FACE_SIZE);
      end else begin
         d = DW'(face_size_ff);
      end
      dm1  = CW'(d - DW'(1));
      xc   = (int'(req_column) > int'(dm1)) ? dm1 : CW'(req_column);
      yc   = (int'(req_row) > int'(dm1)) ? dm1 : CW'(req_row);
      s_in = $signed({1'b0, xc, 1'b0}) - $signed({2'b00, dm1});
      t_in = $signed({1'b0, yc, 1'b0}) - $signed({2'b00, dm1});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start && !busy;
      end
      s1_s_ff    <= s_in;
      s1_t_ff    <= t_in;
      s1_m_ff    <= dm1;
      s1_face_ff <= req_face;
   end

   // stage 2: face selection as magnitude and sign
   always_comb begin
      logic [SW-1:0] sabs, tabs;
      sneg = s1_s_ff[SW-1];
      tneg = s1_t_ff[SW-1];
      sabs = sneg ? SW'(-s1_s_ff) : SW'(s1_s_ff);
      tabs = tneg ? SW'(-s1_t_ff) : SW'(s1_t_ff);
      smag = sabs[CW-1:0];
      tmag = tabs[CW-1:0];
      zero_in = 1'b0;
      unique case (s1_face_ff)
         FACE_POS_X: begin
            mag_in[0] = s1_m_ff; neg_in[0] = 1'b0;
            mag_in[1] = tmag;    neg_in[1] = !tneg;
            mag_in[2] = smag;    neg_in[2] = !sneg;
         end
         FACE_NEG_X: begin
            mag_in[0] = s1_m_ff; neg_in[0] = 1'b1;
            mag_in[1] = tmag;    neg_in[1] = !tneg;
            mag_in[2] = smag;    neg_in[2] = sneg;
         end
         FACE_POS_Y: begin
            mag_in[0] = smag;    neg_in[0] = sneg;
            mag_in[1] = s1_m_ff; neg_in[1] = 1'b0;
            mag_in[2] = tmag;    neg_in[2] = tneg;
         end
         FACE_NEG_Y: begin
            mag_in[0] = smag;    neg_in[0] = sneg;
            mag_in[1] = s1_m_ff; neg_in[1] = 1'b1;
            mag_in[2] = tmag;    neg_in[2] = !tneg;
         end
         FACE_POS_Z: begin
            mag_in[0] = smag;    neg_in[0] = sneg;
            mag_in[1] = tmag;    neg_in[1] = !tneg;
            mag_in[2] = s1_m_ff; neg_in[2] = 1'b0;
         end
         FACE_NEG_Z: begin
            mag_in[0] = smag;    neg_in[0] = !sneg;
            mag_in[1] = tmag;    neg_in[1] = !tneg;
            mag_in[2] = s1_m_ff; neg_in[2] = 1'b1;
         end
         default: begin
            mag_in[0] = '0; neg_in[0] = 1'b0;
            mag_in[1] = '0; neg_in[1] = 1'b0;
            mag_in[2] = '0; neg_in[2] = 1'b0;
            zero_in   = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
      s2_zero_ff <= zero_in;
      s3_zero_ff <= s2_zero_ff;
      s4_zero_ff <= s3_zero_ff;
      for (int i = 0; i < 3; i++) begin
         s2_mag_ff[i] <= mag_in[i];
         s2_neg_ff[i] <= neg_in[i];
         s3_mag_ff[i] <= s2_mag_ff[i];
         s3_neg_ff[i] <= s2_neg_ff[i];
         s3_sq_ff[i]  <= (2*CW)'(s2_mag_ff[i]) * (2*CW)'(s2_mag_ff[i]);
         s4_mag_ff[i] <= s3_mag_ff[i];
         s4_neg_ff[i] <= s3_neg_ff[i];
      end
      s4_len2_ff <= LW'(s3_sq_ff[0]) + LW'(s3_sq_ff[1]) + LW'(s3_sq_ff[2]);
   end

   // square-root chain, one result bit per cell
   assign sq_valid[0] = s4_valid_ff;
   assign sq_rad[0]   = {s4_len2_ff, {(2*RW-LW){1'b0}}};
   assign sq_rem[0]   = '0;
   assign sq_root[0]  = '0;
   assign sq_side[0]  = {s4_zero_ff, s4_neg_ff[0], s4_neg_ff[1], s4_neg_ff[2],
                         s4_mag_ff[0], s4_mag_ff[1], s4_mag_ff[2]};

   for (genvar k = 0; k < RW; k++) begin : g_sqrt
      ncm_sqrt_cell #(.RW(RW), .SIDEW(SIDEW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (sq_valid[k]),
         .in_rad    (sq_rad[k]),
         .in_rem    (sq_rem[k]),
         .in_root   (sq_root[k]),
         .in_side   (sq_side[k]),
         .out_valid (sq_valid[k+1]),
         .out_rad   (sq_rad[k+1]),
         .out_rem   (sq_rem[k+1]),
         .out_root  (sq_root[k+1]),
         .out_side  (sq_side[k+1])
      );
   end

   // divider lanes, one quotient bit per cell
   for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [CW-1:0] lane_mag;
      assign lane_mag = sq_side[RW][(2-l)*CW +: CW];
      assign dv_valid[l][0] = sq_valid[RW];
      assign dv_rem[l][0]   = RW'({lane_mag, {(FRAC_BITS-1){1'b0}}});
      assign dv_div[l][0]   = sq_root[RW];
      assign dv_q[l][0]     = '0;
      assign dv_side[l][0]  = {sq_side[RW][SIDEW-1], sq_side[RW][SIDEW-2-l]};
      for (genvar k = 0; k < QUOT_W; k++) begin : g_div
         ncm_div_cell #(.RW(RW), .SIDEW(2)) u_cell (
            .clock     (clock),
            .reset     (reset),
            .in_valid  (dv_valid[l][k]),
            .in_rem    (dv_rem[l][k]),
            .in_div    (dv_div[l][k]),
            .in_q      (dv_q[l][k]),
            .in_side   (dv_side[l][k]),
            .out_valid (dv_valid[l][k+1]),
            .out_rem   (dv_rem[l][k+1]),
            .out_div   (dv_div[l][k+1]),
            .out_q     (dv_q[l][k+1]),
            .out_side  (dv_side[l][k+1])
         );
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dv_valid[0][QUOT_W];
      end
      red_ff   <= to_color(dv_q[0][QUOT_W], dv_side[0][QUOT_W][0], dv_side[0][QUOT_W][1]);
      green_ff <= to_color(dv_q[1][QUOT_W], dv_side[1][QUOT_W][0], dv_side[1][QUOT_W][1]);
      blue_ff  <= to_color(dv_q[2][QUOT_W], dv_side[2][QUOT_W][0], dv_side[2][QUOT_W][1]);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;

   `NCM_ASSERT_NXT(a_accept_enters, start && !busy, s1_valid_ff)
   `NCM_ASSERT_IMP(a_zero_root, sq_valid[RW] && (sq_root[RW] == '0), sq_side[RW][SIDEW-1])
   `NCM_ASSERT_IMP(a_quot_bound, dv_valid[0][QUOT_W] && !dv_side[0][QUOT_W][1], dv_q[0][QUOT_W] <= QUOT_ONE)
   `NCM_ASSERT_IMP(a_color_range, rsp_valid, (rsp_red <= 8'd254) && (rsp_green <= 8'd254) && (rsp_blue <= 8'd254))
endmodule
`default_nettype wire

@@ tb/tb.sv @@
`default_nettype none
module tb;
   import ncm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY     = 49;
   localparam int WATCHDOG    = 2000;

   typedef struct packed {
      logic [2:0]         face;
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] row;
   } texel_req_type;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } texel_rgb_type;

   typedef struct {
      logic [2:0]         face;
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] row;
      bit                 typed;
      texel_rgb_type      rgb;
   } dir_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [2:0]             req_face = '0;
   logic [COORD_W-1:0]     req_column = '0;
   logic [COORD_W-1:0]     req_row = '0;
   logic                   rsp_valid;
   logic [COLOR_W-1:0]     rsp_red;
   logic [COLOR_W-1:0]     rsp_green;
   logic [COLOR_W-1:0]     rsp_blue;
   logic                   csr_we = 1'b0;
   logic [FACE_SIZE_W-1:0] csr_wdata = '0;

   logic [FACE_SIZE_W-1:0] face_size_model;
   texel_rgb_type          rgb_pending[$];
   int                     errors = 0;
   int                     idle_cycles = 0;
   int                     texels_sent = 0;
   int                     texels_checked = 0;
   int                     face_sizes_used = 0;

   always #2 clock = ~clock;

   normalization_cubemap_texel i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_face(req_face), .req_column(req_column), .req_row(req_row),
      .rsp_valid(rsp_valid), .rsp_red(rsp_red), .rsp_green(rsp_green),
      .rsp_blue(rsp_blue), .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic logic [COLOR_W-1:0] scale_component(longint c, longint unsigned len_q16);
      longint unsigned mag;
      longint unsigned q;
      longint          n;
      if (len_q16 == 0) return COLOR_W'(COLOR_SCALE);
      mag = (c < 0) ? -c : c;
      q = (mag << 32) / len_q16;
      if (q > 64'h10000) q = 64'h10000;
      n = (c < 0) ? -longint'(q) : longint'(q);
      return COLOR_W'(((n + 65536) * COLOR_SCALE) >>> FRAC_BITS);
   endfunction

   function automatic texel_rgb_type texel_direction(texel_req_type r);
      longint d, x, y, s, t, m, vx, vy, vz;
      longint unsigned len2, len_q16;
      texel_rgb_type o;
      d = face_size_model;
      if (d < 2) d = 2;
      if (d > DEF_MAX_FACE_SIZE) d = DEF_MAX_FACE_SIZE;
      x = r.column;
      y = r.row;
      if (x > d - 1) x = d - 1;
      if (y > d - 1) y = d - 1;
      s = 2 * x - (d - 1);
      t = 2 * y - (d - 1);
      m = d - 1;
      case (r.face)
         FACE_POS_X: begin vx = m;  vy = -t; vz = -s; end
         FACE_NEG_X: begin vx = -m; vy = -t; vz = s;  end
         FACE_POS_Y: begin vx = s;  vy = m;  vz = t;  end
         FACE_NEG_Y: begin vx = s;  vy = -m; vz = -t; end
         FACE_POS_Z: begin vx = s;  vy = -t; vz = m;  end
         FACE_NEG_Z: begin vx = -s; vy = -t; vz = -m; end
         default: begin vx = 0; vy = 0; vz = 0; end
      endcase
      len2 = vx * vx + vy * vy + vz * vz;
      len_q16 = int_sqrt(len2 << 32);
      o.red   = scale_component(vx, len_q16);
      o.green = scale_component(vy, len_q16);
      o.blue  = scale_component(vz, len_q16);
      return o;
   endfunction

   // one item per call
   task automatic send_texel(texel_req_type r, bit typed, texel_rgb_type want);
      texel_rgb_type p;
      p = texel_direction(r);
      if (typed && p !== want) begin
         $error("table row face %0d col %0d row %0d: typed %h predicted %h",
                r.face, r.column, r.row, want, p);
         errors++;
      end
      start      <= 1'b1;
      req_face   <= r.face;
      req_column <= r.column;
      req_row    <= r.row;
      do @(posedge clock); while (busy);
      rgb_pending.push_back(p);
      texels_sent++;
   endtask

   task automatic go_idle();
      start <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_face_size(logic [FACE_SIZE_W-1:0] v);
      start <= 1'b0;
      while (rgb_pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      face_size_model = v;
      face_sizes_used++;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            if (rgb_pending.size() == 0) begin
               $error("unexpected item: red %0d green %0d blue %0d", rsp_red, rsp_green,
                      rsp_blue);
               errors++;
            end else begin
               texel_rgb_type e;
               e = rgb_pending.pop_front();
               if (rsp_red !== e.red) begin
                  $error("red expected %0d actual %0d", e.red, rsp_red);
                  errors++;
               end
               if (rsp_green !== e.green) begin
                  $error("green expected %0d actual %0d", e.green, rsp_green);
                  errors++;
               end
               if (rsp_blue !== e.blue) begin
                  $error("blue expected %0d actual %0d", e.blue, rsp_blue);
                  errors++;
               end
               texels_checked++;
            end
         end
         if (rsp_valid || (start && !busy) || csr_we)
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG) begin
            $display("watchdog: no progress, %0d items outstanding", rgb_pending.size());
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   dir_row_type dir_rows[] = '{
      '{FACE_POS_X, 10'd0,    10'd0,    1'b0, '0},
      '{FACE_NEG_X, 10'd0,    10'd0,    1'b0, '0},
      '{FACE_POS_Y, 10'd255,  10'd255,  1'b0, '0},
      '{FACE_NEG_Y, 10'd255,  10'd0,    1'b0, '0},
      '{FACE_POS_Z, 10'd0,    10'd255,  1'b0, '0},
      '{FACE_NEG_Z, 10'd128,  10'd127,  1'b0, '0},
      '{3'd6,       10'd17,   10'd200,  1'b1, '{8'd127, 8'd127, 8'd127}},
      '{3'd7,       10'd1023, 10'd1023, 1'b1, '{8'd127, 8'd127, 8'd127}},
      '{FACE_POS_X, 10'd1023, 10'd1023, 1'b0, '0},
      '{FACE_NEG_Z, 10'd1023, 10'd0,    1'b0, '0},
      '{FACE_POS_Y, 10'd512,  10'd700,  1'b0, '0},
      '{FACE_NEG_X, 10'd128,  10'd128,  1'b0, '0}
   };

   task automatic random_burst(int count, int max_coord);
      texel_req_type r;
      int burst;
      while (count > 0) begin
         burst = $urandom_range(1, 40);
         while (burst > 0 && count > 0) begin
            r.face   = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7))
                                                    : 3'($urandom_range(0, 5));
            if ($urandom_range(0, 7) == 0) begin
               r.column = 10'($urandom);
               r.row    = 10'($urandom);
            end else begin
               r.column = 10'($urandom_range(0, max_coord));
               r.row    = 10'($urandom_range(0, max_coord));
            end
            send_texel(r, 1'b0, '0);
            burst--;
            count--;
         end
         if ($urandom_range(0, 3) != 0) begin
            repeat ($urandom_range(1, 12)) go_idle();
         end
      end
   endtask

   initial begin
      texel_req_type r;
      logic [FACE_SIZE_W-1:0] sizes[] = '{11'd2, 11'd1024, 11'd0, 11'd1, 11'd2047,
                                          11'd1025, 11'd3, 11'd100, 11'd513};
      face_size_model = FACE_SIZE_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         r = '{dir_rows[i].face, dir_rows[i].column, dir_rows[i].row};
         send_texel(r, dir_rows[i].typed, dir_rows[i].rgb);
         if (i % 4 == 3) go_idle();
      end
      random_burst(300, 300);

      foreach (sizes[i]) begin
         write_face_size(sizes[i]);
         random_burst(100, (sizes[i] < 2) ? 3 : int'(sizes[i]) + 2);
      end
      write_face_size(11'($urandom_range(2, 1024)));
      random_burst(330, 1023);

      start <= 1'b0;
      while (rgb_pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);

      $display("%0d texels sent, %0d checked, %0d face size settings incl. out of range",
               texels_sent, texels_checked, face_sizes_used + 1);
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
`default_nettype wire
